// ----- rtl/core/nlc_pkg.sv -----
// Shared types and constants for the name lookup cache.
package nlc_pkg;

    localparam int ENTRIES     = 64;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_BYTES   = 63;
    localparam int KEY_W       = KEY_BYTES * 8;
    localparam int WORD_W      = 64;
    localparam int WORD_BYTES  = WORD_W / 8;
    localparam int NUM_WORDS   = (KEY_W + WORD_W - 1) / WORD_W;
    localparam int PAD_W       = NUM_WORDS * WORD_W;
    localparam int WORD_CNT_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int STAMP_W     = 32;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] name_part0;
        logic [63:0] name_part1;
        logic [63:0] name_part2;
        logic [63:0] name_part3;
        logic [63:0] name_part4;
        logic [63:0] name_part5;
        logic [63:0] name_part6;
        logic [55:0] name_part7;
        logic        found_in;
    } nlc_in_t;

    typedef struct packed {
        logic       hit;
        logic       answer;
        logic [5:0] slot;
    } nlc_out_t;

endpackage

// ----- rtl/core/name_lookup_lru_cache.sv -----
// Top level: fully associative LRU name cache with a sequential entry scan.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_valid / s_ready | s_data  (nlc_in_t: kind, name, found_in)
//  m_      | out | m_valid / m_ready | m_data  (nlc_out_t: hit, answer, slot)
//
// Lookup/store: name normalize, then a scan of the entries (one entry per
// cycle through one key/stamp memory read port), then the output register.
// Clear and unused kinds go straight from accept to ST_DONE and the output register.
// One item at a time; s_ready is low meanwhile.
// A result waits in the output register; the next item is taken while it waits.
// Reset is synchronous; valid bits, clock and control clear at once, no sweep.
module name_lookup_lru_cache (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nlc_pkg::nlc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output nlc_pkg::nlc_out_t m_data
);
    import nlc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PREP   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [KEY_W:0]     key_mem   [ENTRIES];
    logic [STAMP_W-1:0] stamp_mem [ENTRIES];

    logic               is_store_reg;
    logic               found_in_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [STAMP_W-1:0] use_clock_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic               pv_reg;
    logic [IDX_W-1:0]   pidx_reg;
    logic [KEY_W:0]     key_rdata_reg;
    logic [STAMP_W-1:0] stamp_rdata_reg;
    logic               hit_reg;
    logic               hit_ans_reg;
    logic [IDX_W-1:0]   victim_reg;
    logic [STAMP_W-1:0] oldest_reg;
    nlc_out_t           res_reg;
    logic               m_valid_reg;
    nlc_out_t           m_data_reg;

    logic               accept;
    logic               prep_start;
    logic               prep_done;
    logic [KEY_W-1:0]   name_raw;
    logic [KEY_W-1:0]   key;
    logic               match_now;
    logic               empty_now;
    logic               stamp_less;
    logic               scan_end;
    logic               key_wr_en;
    logic               stamp_wr_en;
    logic [STAMP_W-1:0] clock_next;
    logic               out_load;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign name_raw   = {s_data.name_part7, s_data.name_part6, s_data.name_part5,
                         s_data.name_part4, s_data.name_part3, s_data.name_part2,
                         s_data.name_part1, s_data.name_part0};
    assign prep_start = accept && (s_data.kind == KIND_LOOKUP || s_data.kind == KIND_STORE);

    nlc_name_prep u_prep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (prep_start),
        .name_in (name_raw),
        .done    (prep_done),
        .key_out (key)
    );

    // Compare stage of the scan: one key compare and one stamp compare per entry.
    assign match_now  = valid_reg[pidx_reg] && (key_rdata_reg[KEY_W-1:0] == key);
    assign empty_now  = !valid_reg[pidx_reg];
    assign stamp_less = stamp_rdata_reg < oldest_reg;
    assign scan_end   = pv_reg && ((!is_store_reg && match_now) || (is_store_reg && empty_now)
                                   || pidx_reg == IDX_W'(ENTRIES - 1));

    assign clock_next  = use_clock_reg + 1'b1;
    assign key_wr_en   = (state_reg == ST_FINISH) && is_store_reg;
    assign stamp_wr_en = (state_reg == ST_FINISH) && (is_store_reg || hit_reg);
    assign out_load    = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = prep_start ? ST_PREP : ST_DONE;
                end
            end
            ST_PREP: begin
                if (prep_done) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memories: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (key_wr_en) begin
            key_mem[victim_reg] <= {found_in_reg, key};
        end
        key_rdata_reg <= key_mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (stamp_wr_en) begin
            stamp_mem[victim_reg] <= clock_next;
        end
        stamp_rdata_reg <= stamp_mem[rd_idx_reg[IDX_W-1:0]];
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            is_store_reg <= (s_data.kind == KIND_STORE);
            found_in_reg <= s_data.found_in;
            res_reg      <= '0;
        end
        if (state_reg == ST_SCAN && pv_reg) begin
            if (is_store_reg) begin
                if (empty_now || pidx_reg == '0 || stamp_less) begin
                    oldest_reg <= stamp_rdata_reg;
                    victim_reg <= pidx_reg;
                end
            end else if (match_now) begin
                hit_ans_reg <= key_rdata_reg[KEY_W];
                victim_reg  <= pidx_reg;
            end
        end
        if (state_reg == ST_FINISH) begin
            if (is_store_reg) begin
                res_reg <= '{hit: 1'b0, answer: 1'b0, slot: 6'(victim_reg)};
            end else if (hit_reg) begin
                res_reg <= '{hit: 1'b1, answer: hit_ans_reg, slot: 6'(victim_reg)};
            end else begin
                res_reg <= '0;
            end
        end
        if (out_load) begin
            m_data_reg <= res_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            use_clock_reg <= '0;
            rd_idx_reg    <= '0;
            pv_reg        <= 1'b0;
            pidx_reg      <= '0;
            hit_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && s_data.kind == KIND_CLEAR) begin
                valid_reg     <= '0;
                use_clock_reg <= '0;
            end
            if (state_reg == ST_PREP) begin
                rd_idx_reg <= '0;
                pv_reg     <= 1'b0;
                hit_reg    <= 1'b0;
            end
            if (state_reg == ST_SCAN) begin
                if (rd_idx_reg < CNT_W'(ENTRIES)) begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                    pv_reg     <= 1'b1;
                    pidx_reg   <= rd_idx_reg[IDX_W-1:0];
                end else begin
                    pv_reg <= 1'b0;
                end
                if (pv_reg && !is_store_reg && match_now) begin
                    hit_reg <= 1'b1;
                end
            end
            if (stamp_wr_en) begin
                use_clock_reg <= clock_next;
            end
            if (key_wr_en) begin
                valid_reg[victim_reg] <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.kind == KIND_CLEAR) |=> (valid_reg == '0 && use_clock_reg == '0))
        else $error("clear left a valid entry or a nonzero clock");

    a_store_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        key_wr_en |=> valid_reg[$past(victim_reg)])
        else $error("stored entry not marked valid");

    a_pipe_align: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && pv_reg) |-> (rd_idx_reg == CNT_W'(pidx_reg) + 1'b1))
        else $error("scan read pipeline out of step");

    a_answer_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.hit || !m_data_reg.answer))
        else $error("answer set without a hit");

endmodule

// ----- rtl/core/nlc_name_prep.sv -----
// Name normalizer: zeroes every byte from the first zero byte on, one word per cycle.
module nlc_name_prep (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [nlc_pkg::KEY_W-1:0] name_in,
    output logic                      done,
    output logic [nlc_pkg::KEY_W-1:0] key_out
);
    import nlc_pkg::*;

    logic [PAD_W-1:0]      work_reg;
    logic [WORD_CNT_W-1:0] word_cnt_reg;
    logic                  ended_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [WORD_W-1:0]     mword;
    logic                  ended_next;

    always_comb begin
        logic       e;
        logic [7:0] b;
        e = ended_reg;
        mword = '0;
        for (int k = 0; k < WORD_BYTES; k++) begin
            b = work_reg[8*k +: 8];
            if (b == 8'd0) begin
                e = 1'b1;
            end
            mword[8*k +: 8] = e ? 8'd0 : b;
        end
        ended_next = e;
    end

    // Low word is processed and rotated into the top; once all NUM_WORDS words are through, order is restored.
    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= PAD_W'(name_in);
        end else if (busy_reg) begin
            work_reg <= {mword, work_reg[PAD_W-1:WORD_W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            ended_reg    <= 1'b0;
            word_cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg     <= 1'b1;
                ended_reg    <= 1'b0;
                word_cnt_reg <= '0;
            end else if (busy_reg) begin
                ended_reg    <= ended_next;
                word_cnt_reg <= word_cnt_reg + 1'b1;
                if (word_cnt_reg == WORD_CNT_W'(NUM_WORDS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign key_out = work_reg[KEY_W-1:0];

endmodule

// ----- tb/sv/nlc_tb_pkg.sv -----
// Scoreboard class for the name lookup cache: mirrors the cache and checks each reply.
`timescale 1ns / 100ps

package nlc_tb_pkg;

    import nlc_pkg::*;

    // kind 3 has no function in the block; it must come back as an all-zero reply
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    class lookup_tracker;

        bit                 live [ENTRIES];
        bit                 answers [ENTRIES];
        bit [KEY_W-1:0]     keys [ENTRIES];
        bit [STAMP_W-1:0]   stamps [ENTRIES];
        bit [STAMP_W-1:0]   use_clock;
        nlc_out_t           awaited_replies [$];
        int                 mismatches;

        function new();
            foreach (live[i]) begin
                live[i]    = 1'b0;
                answers[i] = 1'b0;
                keys[i]    = '0;
                stamps[i]  = '0;
            end
            use_clock  = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return awaited_replies.size();
        endfunction

        // Name as the cache sees it: everything from the first zero byte on is zero.
        function bit [KEY_W-1:0] trim_name(nlc_in_t item);
            bit [KEY_W-1:0] raw;
            bit             ended;
            int             b;
            raw = {item.name_part7, item.name_part6, item.name_part5, item.name_part4,
                   item.name_part3, item.name_part2, item.name_part1, item.name_part0};
            ended = 1'b0;
            for (b = 0; b < KEY_BYTES; b++) begin
                if (raw[b*8 +: 8] == 8'h00)
                    ended = 1'b1;
                if (ended)
                    raw[b*8 +: 8] = 8'h00;
            end
            return raw;
        endfunction

        function nlc_out_t predict_reply(nlc_in_t item);
            nlc_out_t       r;
            bit [KEY_W-1:0] name;
            int             i;
            int             victim;
            bit [STAMP_W-1:0] oldest;
            r    = '0;
            name = trim_name(item);
            case (item.kind)
                KIND_LOOKUP: begin
                    for (i = 0; i < ENTRIES; i++) begin
                        if (live[i] && keys[i] == name) begin
                            use_clock  = use_clock + 1'b1;
                            stamps[i]  = use_clock;
                            r.hit      = 1'b1;
                            r.answer   = answers[i];
                            r.slot     = IDX_W'(i);
                            break;
                        end
                    end
                end
                KIND_STORE: begin
                    victim = -1;
                    for (i = 0; i < ENTRIES; i++) begin
                        if (!live[i]) begin
                            victim = i;
                            break;
                        end
                    end
                    // full: strictly smallest stamp, lowest index wins a tie
                    if (victim < 0) begin
                        victim = 0;
                        oldest = stamps[0];
                        for (i = 1; i < ENTRIES; i++) begin
                            if (stamps[i] < oldest) begin
                                oldest = stamps[i];
                                victim = i;
                            end
                        end
                    end
                    keys[victim]    = name;
                    answers[victim] = item.found_in;
                    live[victim]    = 1'b1;
                    use_clock       = use_clock + 1'b1;
                    stamps[victim]  = use_clock;
                    r.slot          = IDX_W'(victim);
                end
                KIND_CLEAR: begin
                    foreach (live[i]) begin
                        live[i]   = 1'b0;
                        stamps[i] = '0;
                    end
                    use_clock = '0;
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_request(nlc_in_t item);
            awaited_replies.push_back(predict_reply(item));
        endfunction

        function void check_reply(nlc_out_t got);
            nlc_out_t want;
            if (awaited_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: reply with none pending: hit=%0b answer=%0b slot=%0d",
                             got.hit, got.answer, got.slot);
                return;
            end
            want = awaited_replies.pop_front();
            if (got.hit !== want.hit || got.answer !== want.answer || got.slot !== want.slot)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: reply mismatch: exp hit=%0b answer=%0b slot=%0d, got hit=%0b answer=%0b slot=%0d",
                             want.hit, want.answer, want.slot, got.hit, got.answer, got.slot);
            end
        endfunction

    endclass

endpackage

// ----- tb/sv/name_lookup_lru_cache_test.sv -----
// Top-level test for the name lookup LRU cache: directed and random traffic, scoreboard checks.
`timescale 1ns / 100ps

module name_lookup_lru_cache_test;

    import nlc_pkg::*;
    import nlc_tb_pkg::*;

    localparam int POOL_SIZE       = 96;
    localparam int RANDOM_ITEMS    = 432;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_AT     = 120;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PAUSE_AT        = 300;
    localparam int DRAIN_CYCLES    = 150;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    nlc_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    nlc_out_t m_data;

    lookup_tracker  tracker = new();
    bit [KEY_W-1:0] name_pool [POOL_SIZE];
    int             sent_items = 0;
    int             idle_cycles = 0;

    name_lookup_lru_cache DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // mostly short names, some long, a few filling all 63 bytes
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(1, 12);
        else if (r < 9)
            return $urandom_range(13, 62);
        return KEY_BYTES;
    endfunction

    // noisy: random bytes after the terminating zero, which the cache must ignore
    function automatic bit [KEY_W-1:0] random_name(int len, bit noisy);
        bit [KEY_W-1:0] n;
        int             b;
        n = '0;
        for (b = 0; b < KEY_BYTES; b++) begin
            if (b < len)
                n[b*8 +: 8] = 8'($urandom_range(1, 255));
            else if (noisy && b > len)
                n[b*8 +: 8] = 8'($urandom_range(0, 255));
        end
        return n;
    endfunction

    function automatic bit [KEY_W-1:0] add_tail_noise(bit [KEY_W-1:0] n);
        int z;
        int b;
        z = KEY_BYTES;
        for (b = 0; b < KEY_BYTES; b++) begin
            if (n[b*8 +: 8] == 8'h00) begin
                z = b;
                break;
            end
        end
        for (b = z + 1; b < KEY_BYTES; b++)
            n[b*8 +: 8] = 8'($urandom_range(0, 255));
        return n;
    endfunction

    function automatic nlc_in_t build_item(logic [1:0] kind, bit [KEY_W-1:0] n, bit found);
        nlc_in_t item;
        item.kind       = kind;
        item.name_part0 = n[63:0];
        item.name_part1 = n[127:64];
        item.name_part2 = n[191:128];
        item.name_part3 = n[255:192];
        item.name_part4 = n[319:256];
        item.name_part5 = n[383:320];
        item.name_part6 = n[447:384];
        item.name_part7 = n[503:448];
        item.found_in   = found;
        return item;
    endfunction

    // Called and returns at a falling edge; drives exactly one value of s_valid per step.
    task automatic send_item(nlc_in_t item);
        int gap;
        gap = ((sent_items / 50) % 3 == 2) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.note_request(item);
        sent_items++;
        @(negedge aclk);
    endtask

    task automatic send_fields(logic [1:0] kind, bit [KEY_W-1:0] n, bit found);
        send_item(build_item(kind, n, found));
    endtask

    initial begin : stimulus
        bit [KEY_W-1:0] n;
        bit [KEY_W-1:0] a_name;
        int             i;
        int             r;

        name_pool[0] = '0;
        for (i = 1; i < POOL_SIZE; i++)
            name_pool[i] = random_name(pick_length(), 1'b0);

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part
        send_fields(KIND_LOOKUP, '0, 1'b1);                 // empty cache misses
        send_fields(KIND_STORE, '0, 1'b1);                  // empty name is a legal key
        n = '0;
        n[KEY_W-1:8] = {(KEY_W-8){1'b1}};
        send_fields(KIND_LOOKUP, n, 1'b0);                  // garbage after byte 0 is ignored
        send_fields(KIND_STORE, '1, 1'b0);                  // full 63-byte name
        send_fields(KIND_LOOKUP, '1, 1'b1);
        n = '1;
        n[KEY_W-1 -: 8] = 8'hFE;
        send_fields(KIND_LOOKUP, n, 1'b0);                  // last byte differs: miss
        a_name = '0;
        a_name[7:0] = 8'h61;
        send_fields(KIND_STORE, a_name, 1'b1);
        send_fields(KIND_STORE, a_name, 1'b0);              // duplicate takes a new slot
        send_fields(KIND_LOOKUP, a_name, 1'b0);             // lowest index answers
        send_fields(KIND_UNUSED, '1, 1'b1);
        send_fields(KIND_UNUSED, '0, 1'b0);
        send_fields(KIND_LOOKUP, add_tail_noise(a_name), 1'b1);
        send_fields(KIND_CLEAR, random_name(KEY_BYTES, 1'b0), 1'b1);
        send_fields(KIND_LOOKUP, a_name, 1'b0);             // gone after clear
        send_fields(KIND_STORE, a_name, 1'b0);
        send_fields(KIND_LOOKUP, a_name, 1'b1);
        send_fields(KIND_CLEAR, '0, 1'b0);

        // random part: mostly stores and lookups over a shared name pool
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == PAUSE_AT) begin
                s_valid <= 1'b0;
                while (tracker.pending() != 0) @(negedge aclk);
                @(negedge aclk);
            end
            r = $urandom_range(0, 999);
            if (r < 3)
                send_fields(KIND_CLEAR, random_name(pick_length(), 1'b1), 1'($urandom));
            else if (r < 25)
                send_fields(KIND_UNUSED, random_name(pick_length(), 1'b1), 1'($urandom));
            else if (r < 460)
                send_fields(KIND_STORE, name_pool[$urandom_range(0, POOL_SIZE - 1)],
                            1'($urandom));
            else if (r < 530)
                send_fields(KIND_LOOKUP, random_name(pick_length(), 1'($urandom)),
                            1'($urandom));
            else begin
                n = name_pool[$urandom_range(0, POOL_SIZE - 1)];
                if ($urandom_range(0, 1))
                    n = add_tail_noise(n);
                send_fields(KIND_LOOKUP, n, 1'($urandom));
            end
        end

        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : reply_side
        int gap;
        int replies;
        replies = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            // one long stall so the block backs up into its input
            if (replies == HOLD_OFF_AT) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            gap = ((replies / 40) % 3 == 1) ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            tracker.check_reply(m_data);
            replies++;
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ----- sim.f -----
rtl/core/nlc_pkg.sv
rtl/core/nlc_name_prep.sv
rtl/core/name_lookup_lru_cache.sv
tb/sv/nlc_tb_pkg.sv
tb/sv/name_lookup_lru_cache_test.sv
